// ===== rtl/core/iptb_pkg.sv =====
// Shared types and constants for the IP address text-to-bytes core.
`default_nettype none
package iptb_pkg;

    // Longest text accepted before an overlong-text fault is flagged.
    localparam int MAX_TEXT_LENGTH = 64;
    localparam int CHAR_CNT_W      = $clog2(MAX_TEXT_LENGTH + 1);

    // APB register map
    localparam int APB_ADDR_W = 3;
    localparam logic [APB_ADDR_W-3:0] REG_FAMILY_MODE = 1'b0;

    // family_mode register codes
    localparam logic [1:0] MODE_AUTO  = 2'd0;
    localparam logic [1:0] MODE_FORCE_V4 = 2'd1;
    localparam logic [1:0] MODE_FORCE_V6 = 2'd2;

    // family_out codes
    localparam logic [1:0] FAM_NONE = 2'd0;
    localparam logic [1:0] FAM_V4   = 2'd1;
    localparam logic [1:0] FAM_V6   = 2'd2;

    // status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NO_FAMILY = 3'd1;
    localparam logic [2:0] ST_V4_EMPTY  = 3'd2;
    localparam logic [2:0] ST_BAD_DIGIT = 3'd3;
    localparam logic [2:0] ST_V4_RANGE  = 3'd4;
    localparam logic [2:0] ST_V6_DOT    = 3'd5;
    localparam logic [2:0] ST_V6_RANGE  = 3'd6;
    localparam logic [2:0] ST_BAD_COUNT = 3'd7;

    // Separator characters
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_COLON = 8'h3a;

    // Input beat: one character of address text.
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } in_beat_t;

    // Result beat.
    typedef struct packed {
        logic [63:0] addr_high;
        logic [63:0] addr_low;
        logic [1:0]  family_out;
        logic [2:0]  status;
    } out_beat_t;

    // Parse state at the end of one text, handed from parser to formatter.
    // err: [2:0] first IPv4 fault, [5:3] first IPv6 fault, [6] text too long.
    typedef struct packed {
        logic [3:0][7:0]  v4_bytes;
        logic [2:0]       v4_cnt;
        logic [7:0][15:0] v6_groups;
        logic [3:0]       v6_cnt;
        logic             gap_seen;
        logic [3:0]       gap_pos;
        logic [1:0]       seen;
        logic [6:0]       err;
    } fin_t;

endpackage
`default_nettype wire

// ===== rtl/core/iptb_parse.sv =====
// Per-character parser: IPv4 and IPv6 views updated in parallel.
`default_nettype none
module iptb_parse (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             step,
    input  wire iptb_pkg::in_beat_t beat,
    output iptb_pkg::fin_t        fin
);
    import iptb_pkg::*;

    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      cnt;
        logic [8:0]      acc;
        logic [2:0]      dig;
        logic [2:0]      err;
    } v4_state_t;

    typedef struct packed {
        logic [7:0][15:0] groups;
        logic [3:0]       cnt;
        logic [16:0]      acc;
        logic [2:0]       len;
        logic [2:0]       err;
    } v6_state_t;

    function automatic v4_state_t v4_close(input v4_state_t s);
        v4_state_t r;
        r = s;
        if (s.dig == 3'd0) begin
            if (r.err == ST_OK) r.err = ST_V4_EMPTY;
        end else if (s.cnt < 3'd4) begin
            for (int k = 0; k < 4; k++) begin
                if (s.cnt[1:0] == 2'(k)) r.bytes[k] = s.acc[7:0];
            end
        end
        if (s.cnt < 3'd5) r.cnt = s.cnt + 3'd1;
        r.acc = '0;
        r.dig = '0;
        return r;
    endfunction

    function automatic v6_state_t v6_close(input v6_state_t s);
        v6_state_t r;
        r = s;
        if (s.cnt < 4'd8) begin
            for (int k = 0; k < 8; k++) begin
                if (s.cnt[2:0] == 3'(k)) r.groups[k] = s.acc[15:0];
            end
        end
        if (s.cnt < 4'd9) r.cnt = s.cnt + 4'd1;
        r.acc = '0;
        r.len = '0;
        return r;
    endfunction

    // {valid, value}
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] r;
        r = '0;
        if (c >= 8'h30 && c <= 8'h39)      r = {1'b1, c[3:0]};
        else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, c[3:0] + 4'd9};
        else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, c[3:0] + 4'd9};
        return r;
    endfunction

    v4_state_t             v4_reg, v4_next;
    v6_state_t             v6_reg, v6_next;
    logic                  gap_seen_reg, gap_seen_next;
    logic [3:0]            gap_pos_reg, gap_pos_next;
    logic [1:0]            seen_reg, seen_next;
    logic                  long_reg, long_next;
    logic [CHAR_CNT_W-1:0] char_cnt_reg, char_cnt_next;
    logic                  prev_colon_reg, prev_colon_next;
    logic                  colon_pair_reg, colon_pair_next;
    logic                  lead_colon_reg, lead_colon_next;

    logic        dec_ok;
    logic [11:0] dec_sum;
    logic [4:0]  hex;
    logic [20:0] hex_sum;

    always_comb begin
        v4_next         = v4_reg;
        v6_next         = v6_reg;
        gap_seen_next   = gap_seen_reg;
        gap_pos_next    = gap_pos_reg;
        seen_next       = seen_reg;
        long_next       = long_reg;
        char_cnt_next   = char_cnt_reg;
        prev_colon_next = prev_colon_reg;
        colon_pair_next = colon_pair_reg;
        lead_colon_next = lead_colon_reg;

        dec_ok  = (beat.ch >= 8'h30) && (beat.ch <= 8'h39);
        dec_sum = 12'({v4_reg.acc, 3'b000}) + 12'({v4_reg.acc, 1'b0}) + 12'(beat.ch[3:0]);
        hex     = hex_value(beat.ch);
        hex_sum = 21'({v6_reg.acc, 4'b0000}) + 21'(hex[3:0]);

        if (char_cnt_reg >= CHAR_CNT_W'(MAX_TEXT_LENGTH)) long_next = 1'b1;
        else char_cnt_next = char_cnt_reg + CHAR_CNT_W'(1);

        // IPv4 view
        if (beat.ch == CH_DOT) begin
            seen_next[1] = 1'b1;
            v4_next = v4_close(v4_next);
        end else begin
            if (dec_ok) begin
                v4_next.acc = (dec_sum > 12'd256) ? 9'd256 : dec_sum[8:0];
                if (v4_next.acc > 9'd255 && v4_next.err == ST_OK) v4_next.err = ST_V4_RANGE;
            end else if (v4_next.err == ST_OK) begin
                v4_next.err = ST_BAD_DIGIT;
            end
            if (v4_next.dig < 3'd7) v4_next.dig = v4_next.dig + 3'd1;
        end

        // IPv6 view
        if (lead_colon_reg) begin
            if (beat.ch != CH_COLON && v6_next.err == ST_OK) v6_next.err = ST_BAD_COUNT;
            lead_colon_next = 1'b0;
        end
        if (beat.ch == CH_COLON) begin
            seen_next[0]    = 1'b1;
            colon_pair_next = prev_colon_reg;
            if (prev_colon_reg) begin
                if (gap_seen_reg) begin
                    if (v6_next.err == ST_OK) v6_next.err = ST_BAD_COUNT;
                end else begin
                    gap_seen_next = 1'b1;
                    gap_pos_next  = v6_reg.cnt;
                end
            end else if (v6_reg.len != 3'd0) begin
                v6_next = v6_close(v6_next);
            end else begin
                lead_colon_next = 1'b1;
            end
            prev_colon_next = 1'b1;
        end else begin
            prev_colon_next = 1'b0;
            if (beat.ch == CH_DOT) begin
                if (v6_next.err == ST_OK) v6_next.err = ST_V6_DOT;
            end else if (hex[4]) begin
                v6_next.acc = (hex_sum > 21'h10000) ? 17'h10000 : hex_sum[16:0];
                if (v6_next.acc > 17'h0ffff && v6_next.err == ST_OK) v6_next.err = ST_V6_RANGE;
            end else if (v6_next.err == ST_OK) begin
                v6_next.err = ST_BAD_DIGIT;
            end
            if (v6_next.len < 3'd7) v6_next.len = v6_next.len + 3'd1;
        end

        // End of text: close open groups, check dangling colons.
        if (beat.last) begin
            v4_next = v4_close(v4_next);
            if (v6_next.len != 3'd0) begin
                v6_next = v6_close(v6_next);
            end else if (prev_colon_next && !colon_pair_next && v6_next.err == ST_OK) begin
                v6_next.err = ST_BAD_COUNT;
            end
            if (lead_colon_next && v6_next.err == ST_OK) v6_next.err = ST_BAD_COUNT;
        end
    end

    assign fin.v4_bytes  = v4_next.bytes;
    assign fin.v4_cnt    = v4_next.cnt;
    assign fin.v6_groups = v6_next.groups;
    assign fin.v6_cnt    = v6_next.cnt;
    assign fin.gap_seen  = gap_seen_next;
    assign fin.gap_pos   = gap_pos_next;
    assign fin.seen      = seen_next;
    assign fin.err       = {long_next, v6_next.err, v4_next.err};

    // Last character restarts the parse for the next text.
    always_ff @(posedge aclk) begin
        if (!aresetn || (step && beat.last)) begin
            v4_reg         <= '0;
            v6_reg         <= '0;
            gap_seen_reg   <= 1'b0;
            gap_pos_reg    <= '0;
            seen_reg       <= '0;
            long_reg       <= 1'b0;
            char_cnt_reg   <= '0;
            prev_colon_reg <= 1'b0;
            colon_pair_reg <= 1'b0;
            lead_colon_reg <= 1'b0;
        end else if (step) begin
            v4_reg         <= v4_next;
            v6_reg         <= v6_next;
            gap_seen_reg   <= gap_seen_next;
            gap_pos_reg    <= gap_pos_next;
            seen_reg       <= seen_next;
            long_reg       <= long_next;
            char_cnt_reg   <= char_cnt_next;
            prev_colon_reg <= prev_colon_next;
            colon_pair_reg <= colon_pair_next;
            lead_colon_reg <= lead_colon_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/iptb_format.sv =====
// Result builder: family choice, status priority and '::' expansion.
`default_nettype none
module iptb_format (
    input  wire logic [1:0]      family_mode,
    input  wire iptb_pkg::fin_t  fin,
    output iptb_pkg::out_beat_t res
);
    import iptb_pkg::*;

    logic [1:0]       fam;
    logic [2:0]       code;
    logic [4:0]       zeros;
    logic [4:0]       split;
    logic [7:0][15:0] placed;
    logic [127:0]     addr;

    always_comb begin
        unique case (family_mode)
            MODE_FORCE_V4: fam = FAM_V4;
            MODE_FORCE_V6: fam = FAM_V6;
            default: fam = fin.seen[0] ? FAM_V6 : (fin.seen[1] ? FAM_V4 : FAM_NONE);
        endcase

        priority if (fam == FAM_NONE) begin
            code = ST_NO_FAMILY;
        end else if (fin.err[6]) begin
            code = ST_BAD_COUNT;
        end else if (fam == FAM_V4) begin
            code = fin.err[2:0];
            if (code == ST_OK && fin.v4_cnt != 3'd4) code = ST_BAD_COUNT;
        end else begin
            code = fin.err[5:3];
            if (code == ST_OK && (fin.gap_seen ? (fin.v6_cnt > 4'd7) : (fin.v6_cnt != 4'd8)))
                code = ST_BAD_COUNT;
        end

        // Groups before the gap keep their place; the rest shift right by the zero run.
        zeros = fin.gap_seen ? (5'd8 - 5'(fin.v6_cnt)) : 5'd0;
        split = fin.gap_seen ? 5'(fin.gap_pos) : 5'(fin.v6_cnt);
        placed = '0;
        for (int p = 0; p < 8; p++) begin
            for (int i = 0; i < 8; i++) begin
                if ((5'(i) < 5'(fin.v6_cnt)) &&
                    (((5'(p) < split) && (i == p)) ||
                     ((5'(p) >= split + zeros) && (5'(i) + zeros == 5'(p)))))
                    placed[p] = placed[p] | fin.v6_groups[i];
            end
        end

        addr = '0;
        if (code == ST_OK) begin
            if (fam == FAM_V4) begin
                addr[127:96] = {fin.v4_bytes[0], fin.v4_bytes[1],
                                fin.v4_bytes[2], fin.v4_bytes[3]};
            end else begin
                for (int p = 0; p < 8; p++) addr[127 - 16*p -: 16] = placed[p];
            end
        end

        res.addr_high  = addr[127:64];
        res.addr_low   = addr[63:0];
        res.family_out = fam;
        res.status     = code;
    end

endmodule
`default_nettype wire

// ===== rtl/core/ip_address_text_to_bytes_core.sv =====
// Top level of the IP address text-to-bytes core.
// Usage:
//  - s_ channel: one ASCII character per beat (s_payload.ch), s_payload.last
//    marks the final character of an address text.
//  - m_ channel: one result beat per text, emitted for the last character:
//    16 address bytes (addr_high/addr_low, byte 0 in the top bits, IPv4 in
//    addr_high[63:32]), the chosen family and a status code. On any fault
//    the address bytes are zero.
//  - APB port: one register, family_mode at byte address 0 (0 auto,
//    1 force IPv4, 2 force IPv6). Write it only while the core is idle.
// Timing:
//  - One character per cycle sustained while s_ready stays high; the parse
//    state update for each character is registered, so characters stream back to back.
//  - A result passes through the input register, the end-of-text snapshot
//    and the result register, in that order.
// Reset: aresetn (sync, active low) clears the parse state, all valids and
//   family_mode; the core accepts a beat in the first cycle after reset.
// Stalls: if m_ready is low, the snapshot stage still absorbs one more text;
//   non-last characters keep flowing, and s_ready drops only when a last
//   character finds both the snapshot and result registers full.
`default_nettype none
module ip_address_text_to_bytes_core (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    // character input
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire iptb_pkg::in_beat_t  s_payload,
    // result output
    output logic                     m_valid,
    input  wire logic                m_ready,
    output iptb_pkg::out_beat_t      m_payload,
    // configuration
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [iptb_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [31:0]         pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);
    import iptb_pkg::*;

    // configuration register
    logic [1:0] family_mode_reg;
    logic       cfg_sel;

    assign pready  = 1'b1;
    assign cfg_sel = (paddr[APB_ADDR_W-1:2] == REG_FAMILY_MODE);
    assign prdata  = cfg_sel ? {30'd0, family_mode_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            family_mode_reg <= MODE_AUTO;
        end else if (psel && penable && pwrite && pready && cfg_sel) begin
            family_mode_reg <= pwdata[1:0];
        end
    end

    // pipeline registers
    logic      in_valid_reg;
    in_beat_t  in_reg;
    logic      fin_valid_reg;
    fin_t      fin_reg;
    logic      m_valid_reg;
    out_beat_t m_payload_reg;

    fin_t      fin_now;
    out_beat_t res_now;

    logic out_free, fin_free, fin_adv, in_adv;

    // Ready chain: a slot is free if empty or its content leaves this cycle.
    assign out_free = !m_valid_reg || m_ready;
    assign fin_adv  = fin_valid_reg && out_free;
    assign fin_free = !fin_valid_reg || out_free;
    // Non-last characters only touch parse state, so they never wait.
    assign in_adv   = in_valid_reg && (!in_reg.last || fin_free);
    assign s_ready  = !in_valid_reg || in_adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) in_reg <= s_payload;
    end

    iptb_parse u_parse (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (in_adv),
        .beat    (in_reg),
        .fin     (fin_now)
    );

    // end-of-text snapshot
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fin_valid_reg <= 1'b0;
        end else begin
            if (fin_adv) fin_valid_reg <= 1'b0;
            if (in_adv && in_reg.last) fin_valid_reg <= 1'b1;
        end
        if (in_adv && in_reg.last) fin_reg <= fin_now;
    end

    iptb_format u_format (
        .family_mode (family_mode_reg),
        .fin         (fin_reg),
        .res         (res_now)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;
            if (fin_adv) m_valid_reg <= 1'b1;
        end
        if (fin_adv) m_payload_reg <= res_now;
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    // no family is reported only with the no-family status
    a_no_family: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (m_payload_reg.family_out == FAM_NONE)
        |-> (m_payload_reg.status == ST_NO_FAMILY))
        else $error("no family without no-family status");

    // faulted results carry zero address bytes
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (m_payload_reg.status != ST_OK)
        |-> (m_payload_reg.addr_high == 64'd0) && (m_payload_reg.addr_low == 64'd0))
        else $error("faulted result with nonzero address");

    // IPv4 results occupy only the top 32 bits
    a_v4_place: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (m_payload_reg.status == ST_OK) && (m_payload_reg.family_out == FAM_V4)
        |-> (m_payload_reg.addr_low == 64'd0) && (m_payload_reg.addr_high[31:0] == 32'd0))
        else $error("IPv4 bytes outside top 32 bits");

    // a held snapshot is neither lost nor altered while the output stalls
    a_fin_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        fin_valid_reg && !out_free |=> fin_valid_reg && $stable(fin_reg))
        else $error("snapshot lost under stall");

    // a taken result with nothing behind it leaves the output empty
    a_no_dup: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_ready && !fin_valid_reg |=> !m_valid_reg)
        else $error("result repeated");

endmodule
`default_nettype wire

// ===== tb/tb_ip_address_text_to_bytes_core.sv =====
// Self-checking testbench for the IP address text-to-bytes core.
`default_nettype none
module tb_ip_address_text_to_bytes_core;
    timeunit 1ns;
    timeprecision 1ps;

    import iptb_pkg::*;

    // Byte addresses of the config registers; index 1 is unmapped and must be ignored.
    localparam logic [APB_ADDR_W-1:0] MODE_ADDR       = {REG_FAMILY_MODE, 2'b00};
    localparam logic [APB_ADDR_W-1:0] UNUSED_REG_ADDR = 3'd4;
    // Mode code 3 has no name in the package; it behaves like auto-detect.
    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 6;   // margin for results still in the core's registers
    localparam int PHASE_CHARS    = 44;  // ~220 characters over five random phases

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_beat_t    s_payload = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_beat_t   m_payload;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    ip_address_text_to_bytes_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_payload(s_payload),
        .m_valid(m_valid), .m_ready(m_ready), .m_payload(m_payload),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #4 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Parser mirror: both views (IPv4 and IPv6) run on every character,
    // the family is chosen on the last one.
    // ------------------------------------------------------------------
    logic [1:0]  mode_cfg = MODE_AUTO;
    logic [7:0]  v4_oct [4];
    int          v4_groups_n;
    logic [15:0] v6_grp [8];
    int          v6_groups_n;
    int          dec_acc;          // saturates at 256
    int          hex_acc;          // saturates at 0x10000
    int          v4_digits;        // saturates at 7
    int          v6_digits;        // saturates at 7
    logic        dbl_colon_seen;
    int          dbl_colon_at;
    logic [1:0]  seen_sep;         // [0] colon, [1] dot
    logic [2:0]  v4_fault;         // first fault wins
    logic [2:0]  v6_fault;
    logic        text_too_long;
    int          text_len;
    logic        prev_was_colon;
    logic        colon_run;        // current colon followed another colon
    logic        pending_lead_colon;

    out_beat_t   addr_results_q[$];
    logic [7:0]  text_buf[$];      // characters of the next text to send

    int          err_cnt = 0;
    int          idle_cycles = 0;
    int          ready_hold = 0;
    int          chars_sent = 0;
    bit          idle_on = 1'b1;
    out_beat_t   want;

    task automatic clear_parse();
        foreach (v4_oct[i]) v4_oct[i] = '0;
        foreach (v6_grp[i]) v6_grp[i] = '0;
        v4_groups_n = 0; v6_groups_n = 0;
        dec_acc = 0; hex_acc = 0; v4_digits = 0; v6_digits = 0;
        dbl_colon_seen = 1'b0; dbl_colon_at = 0; seen_sep = '0;
        v4_fault = ST_OK; v6_fault = ST_OK; text_too_long = 1'b0; text_len = 0;
        prev_was_colon = 1'b0; colon_run = 1'b0; pending_lead_colon = 1'b0;
    endtask

    task automatic note_v4_fault(input logic [2:0] code);
        if (v4_fault == ST_OK) v4_fault = code;
    endtask

    task automatic note_v6_fault(input logic [2:0] code);
        if (v6_fault == ST_OK) v6_fault = code;
    endtask

    task automatic close_v4_group();
        if (v4_digits == 0) note_v4_fault(ST_V4_EMPTY);
        else if (v4_groups_n < 4) v4_oct[v4_groups_n] = dec_acc[7:0];
        if (v4_groups_n < 5) v4_groups_n++;
        dec_acc = 0;
        v4_digits = 0;
    endtask

    task automatic close_v6_group();
        if (v6_groups_n < 8) v6_grp[v6_groups_n] = hex_acc[15:0];
        if (v6_groups_n < 9) v6_groups_n++;
        hex_acc = 0;
        v6_digits = 0;
    endtask

    function automatic int hex_digit_value(input logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c) - int'("0");
        if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
        if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
        return -1;
    endfunction

    // Update the mirror with one accepted character; queue a result on last.
    task automatic parse_char(input logic [7:0] c, input logic lst);
        int h, pos, zeros, split;
        logic [1:0] fam;
        logic [2:0] code;
        logic [127:0] addr;
        out_beat_t res;

        if (text_len >= MAX_TEXT_LENGTH) text_too_long = 1'b1;
        else text_len++;

        // IPv4 view
        if (c == CH_DOT) begin
            seen_sep[1] = 1'b1;
            close_v4_group();
        end else begin
            if (c >= "0" && c <= "9") begin
                dec_acc = dec_acc * 10 + (int'(c) - int'("0"));
                if (dec_acc > 256) dec_acc = 256;
                if (dec_acc > 255) note_v4_fault(ST_V4_RANGE);
            end else begin
                note_v4_fault(ST_BAD_DIGIT);
            end
            if (v4_digits < 7) v4_digits++;
        end

        // IPv6 view
        if (pending_lead_colon) begin
            if (c != CH_COLON) note_v6_fault(ST_BAD_COUNT);
            pending_lead_colon = 1'b0;
        end
        if (c == CH_COLON) begin
            seen_sep[0] = 1'b1;
            colon_run = prev_was_colon;
            if (prev_was_colon) begin
                if (dbl_colon_seen) note_v6_fault(ST_BAD_COUNT);
                else begin
                    dbl_colon_seen = 1'b1;
                    dbl_colon_at = v6_groups_n;
                end
            end else if (v6_digits > 0) begin
                close_v6_group();
            end else begin
                pending_lead_colon = 1'b1;
            end
            prev_was_colon = 1'b1;
        end else begin
            h = hex_digit_value(c);
            prev_was_colon = 1'b0;
            if (c == CH_DOT) begin
                note_v6_fault(ST_V6_DOT);
            end else if (h >= 0) begin
                hex_acc = hex_acc * 16 + h;
                if (hex_acc > 32'h10000) hex_acc = 32'h10000;
                if (hex_acc > 32'hffff) note_v6_fault(ST_V6_RANGE);
            end else begin
                note_v6_fault(ST_BAD_DIGIT);
            end
            if (v6_digits < 7) v6_digits++;
        end

        if (!lst) return;

        // end of text
        close_v4_group();
        if (v6_digits > 0) close_v6_group();
        else if (prev_was_colon && !colon_run) note_v6_fault(ST_BAD_COUNT); // lone trailing ':'
        if (pending_lead_colon) note_v6_fault(ST_BAD_COUNT);

        if (mode_cfg == MODE_FORCE_V4) fam = FAM_V4;
        else if (mode_cfg == MODE_FORCE_V6) fam = FAM_V6;
        else fam = seen_sep[0] ? FAM_V6 : (seen_sep[1] ? FAM_V4 : FAM_NONE);

        addr = '0;
        if (fam == FAM_NONE) begin
            code = ST_NO_FAMILY;
        end else if (text_too_long) begin
            code = ST_BAD_COUNT;
        end else if (fam == FAM_V4) begin
            code = v4_fault;
            if (code == ST_OK && v4_groups_n != 4) code = ST_BAD_COUNT;
            if (code == ST_OK) addr[127:96] = {v4_oct[0], v4_oct[1], v4_oct[2], v4_oct[3]};
        end else begin
            code = v6_fault;
            if (code == ST_OK && (dbl_colon_seen ? (v6_groups_n > 7) : (v6_groups_n != 8)))
                code = ST_BAD_COUNT;
            if (code == ST_OK) begin
                // '::' expands to the zero groups that make eight
                pos = 0;
                zeros = dbl_colon_seen ? 8 - v6_groups_n : 0;
                split = dbl_colon_seen ? dbl_colon_at : v6_groups_n;
                for (int i = 0; i < v6_groups_n && i < 8; i++) begin
                    if (i == split) pos += zeros;
                    if (pos < 8) addr[127 - 16 * pos -: 16] = v6_grp[i];
                    pos++;
                end
            end
        end

        res.addr_high  = addr[127:64];
        res.addr_low   = addr[63:0];
        res.family_out = fam;
        res.status     = code;
        addr_results_q = {addr_results_q, res};
        clear_parse();
    endtask

    // ------------------------------------------------------------------
    // Result checker, sink stalls and watchdog, all sampled at posedge.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable && pready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: timeout, no beat for %0d cycles", $time, idle_cycles);
                $display("DONE: errors detected");
                $finish;
            end
            if (m_valid && m_ready) begin
                if (addr_results_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h", $time, m_payload);
                    err_cnt++;
                end else begin
                    want = addr_results_q.pop_front();
                    if (m_payload.addr_high !== want.addr_high) begin
                        $display("%0t: addr_high expected %h actual %h",
                                 $time, want.addr_high, m_payload.addr_high);
                        err_cnt++;
                    end
                    if (m_payload.addr_low !== want.addr_low) begin
                        $display("%0t: addr_low expected %h actual %h",
                                 $time, want.addr_low, m_payload.addr_low);
                        err_cnt++;
                    end
                    if (m_payload.family_out !== want.family_out) begin
                        $display("%0t: family_out expected %0d actual %0d",
                                 $time, want.family_out, m_payload.family_out);
                        err_cnt++;
                    end
                    if (m_payload.status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, m_payload.status);
                        err_cnt++;
                    end
                end
                ready_hold = idle_on ? $urandom_range(0, 6) : 0;
            end
        end
    end

    // sink: hold m_ready low for the drawn number of cycles after each beat
    always @(negedge aclk) begin
        if (ready_hold > 0) begin
            m_ready <= 1'b0;
            ready_hold--;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    task automatic send_char(input logic [7:0] c, input logic lst);
        int gap;
        in_beat_t beat;
        gap = idle_on ? $urandom_range(0, 6) : 0;
        beat.ch = c;
        beat.last = lst;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_payload <= beat;
        do @(posedge aclk); while (!s_ready);
        parse_char(c, lst);
        chars_sent++;
    endtask

    // sends text_buf, last flag on its final character
    task automatic send_text();
        idle_on = ($urandom_range(0, 3) != 0);
        foreach (text_buf[i]) send_char(text_buf[i], i == text_buf.size() - 1);
    endtask

    // appends one character to the text being built
    task automatic append_char(input logic [7:0] c);
        text_buf = {text_buf, c};
    endtask

    task automatic push_str(input string s);
        for (int i = 0; i < s.len(); i++) append_char(s[i]);
    endtask

    // wait for every pending result, then for the core's latency
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (addr_results_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // one APB transfer; reads check against the mirrored mode
    task automatic apb_access(input logic wr, input logic [APB_ADDR_W-1:0] addr,
                              input logic [31:0] data);
        @(negedge aclk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= wr; paddr <= addr; pwdata <= data;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (wr && addr == MODE_ADDR) mode_cfg = data[1:0];
        if (!wr && prdata !== {30'd0, mode_cfg}) begin
            $display("%0t: family_mode readback expected %h actual %h",
                     $time, {30'd0, mode_cfg}, prdata);
            err_cnt++;
        end
        @(negedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic set_mode(input logic [1:0] m);
        drain();
        apb_access(1'b1, MODE_ADDR, {30'($urandom_range(0, 32'h3fff_ffff)), m});
        apb_access(1'b0, MODE_ADDR, '0);
    endtask

    // ------------------------------------------------------------------
    // Text generators (append to text_buf)
    // ------------------------------------------------------------------
    task automatic gen_v4(input bit wild);
        int v;
        for (int g = 0; g < 4; g++) begin
            if (g > 0) append_char(CH_DOT);
            if ($urandom_range(0, 7) == 0) repeat ($urandom_range(1, 2)) push_str("0");
            v = $urandom_range(0, 255);
            if (wild && $urandom_range(0, 2) == 0) v = $urandom_range(256, 99999);
            push_str($sformatf("%0d", v));
        end
    endtask

    task automatic gen_v6(input bit wild);
        int n, gp, v;
        bit gap;
        string s;
        gap = ($urandom_range(0, 2) == 0);
        n = gap ? $urandom_range(0, 7) : 8;
        gp = gap ? $urandom_range(0, n) : n;
        for (int g = 0; g < n; g++) begin
            if (g == gp) push_str("::");
            else if (g > 0) append_char(CH_COLON);
            v = $urandom_range(0, 16'hffff);
            if ($urandom_range(0, 3) == 0) v = $urandom_range(0, 15);
            if (wild && $urandom_range(0, 2) == 0) v = $urandom_range(32'h10000, 32'hfffff);
            s = $sformatf("%0x", v);
            if ($urandom_range(0, 1)) s = s.toupper();
            if (s.len() < 4 && $urandom_range(0, 3) == 0) push_str("0");
            push_str(s);
        end
        if (gap && gp == n) push_str("::");
    endtask

    // damage a well-formed text in one place
    task automatic mutate_text();
        int pos;
        string seps;
        seps = ".:0123456789abcdefxX+- ";
        pos = $urandom_range(0, text_buf.size() - 1);
        case ($urandom_range(0, 4))
            0: text_buf[pos] = 8'($urandom_range(0, 255));
            1: if (text_buf.size() > 1) text_buf.delete(pos);
            2: text_buf.insert(pos, seps[$urandom_range(0, seps.len() - 1)]);
            3: append_char($urandom_range(0, 1) ? CH_COLON : CH_DOT);
            default: text_buf.insert(pos, 8'($urandom_range(0, 255)));
        endcase
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // edge values and every fault class, auto-detect mode
    task automatic test_directed();
        string texts[$] = '{
            "0.0.0.0", "255.255.255.255", "192.168.001.010", "256.1.1.1", "1..2.3",
            "1.2.3", "1.2.3.4.5", ".1.2.3", "+1.2.3.4", "0x1.2.3.4", "1.2.3.4 ",
            "::", "::1", "1::", "1:2:3:4:5:6:7:8", "ffff:FFFF:0:0:0:0:0:abcd",
            "12::34:56", "1:2::3::4", ":::", ":1:2:3:4:5:6:7", "1:2:3:4:5:6:7:",
            "1:2:3:4:5:6:7", "1:2:3:4:5:6:7:8:9", "1:2:3:4::5:6:7:8", "10000::",
            "::1.2.3.4", "abc", "g::1", ":"};
        foreach (texts[i]) begin
            text_buf.delete();
            push_str(texts[i]);
            send_text();
        end
        // extreme character codes
        text_buf.delete();
        append_char(8'h00);
        append_char(8'hff);
        append_char(CH_DOT);
        send_text();
    endtask

    // forced families, the spare mode code and the unmapped register
    task automatic test_family_modes();
        string v4_texts[$] = '{"1.2.3.4", "1:2::3", "abc"};
        string v6_texts[$] = '{"1.2.3.4", "::ffff", "abc"};
        string spare_texts[$] = '{"::1", "10.0.0.1", "xyz"};
        set_mode(MODE_FORCE_V4);
        foreach (v4_texts[i]) begin text_buf.delete(); push_str(v4_texts[i]); send_text(); end
        set_mode(MODE_FORCE_V6);
        foreach (v6_texts[i]) begin text_buf.delete(); push_str(v6_texts[i]); send_text(); end
        set_mode(MODE_SPARE);
        foreach (spare_texts[i]) begin
            text_buf.delete();
            push_str(spare_texts[i]);
            send_text();
        end
        drain();
        apb_access(1'b1, UNUSED_REG_ADDR, 32'hffff_fff1);
        apb_access(1'b0, MODE_ADDR, '0);
        text_buf.delete();
        push_str("1.2.3.4");
        send_text();
        set_mode(MODE_AUTO);
    endtask

    // texts right at and just past the length limit
    task automatic test_text_length();
        for (int extra = 0; extra < 2; extra++) begin
            text_buf.delete();
            repeat (MAX_TEXT_LENGTH - 7 + extra) push_str("0");
            push_str("1.2.3.4");
            send_text();
        end
        text_buf.delete();
        repeat (MAX_TEXT_LENGTH + 6) push_str("a");
        send_text();
        text_buf.delete();
        repeat (MAX_TEXT_LENGTH + 2) push_str("f");
        push_str("::");
        send_text();
    endtask

    task automatic test_random();
        logic [1:0] modes[5] = '{MODE_AUTO, MODE_FORCE_V4, MODE_FORCE_V6, MODE_SPARE, MODE_AUTO};
        int sel, start;
        foreach (modes[p]) begin
            set_mode(modes[p]);
            start = chars_sent;
            while (chars_sent - start < PHASE_CHARS) begin
                text_buf.delete();
                sel = $urandom_range(0, 39);
                if (sel < 14) gen_v4(1'b0);
                else if (sel < 28) gen_v6(1'b0);
                else if (sel < 32) begin
                    if ($urandom_range(0, 1)) gen_v4(1'b1); else gen_v6(1'b1);
                end else if (sel < 37) begin
                    if ($urandom_range(0, 1)) gen_v4(1'b0); else gen_v6(1'b0);
                    mutate_text();
                end else if (sel < 39) begin
                    repeat ($urandom_range(1, 8)) append_char(8'($urandom_range(0, 255)));
                end else begin
                    // long text that may or may not cross the limit
                    repeat ($urandom_range(50, 60)) push_str("0");
                    gen_v4(1'b0);
                end
                send_text();
            end
        end
    endtask

    initial begin
        clear_parse();
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_text_length();
        test_family_modes();
        test_random();
        drain();

        if (err_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
`default_nettype wire

// ===== files.f =====
rtl/core/iptb_pkg.sv
rtl/core/iptb_parse.sv
rtl/core/iptb_format.sv
rtl/core/ip_address_text_to_bytes_core.sv
tb/tb_ip_address_text_to_bytes_core.sv
